### sv/rgb2hsv_pkg.sv
// rgb2hsv_pkg: shared types, constants and the divider step for the rgb to hsv pipeline
package rgb2hsv_pkg;

	localparam int unsigned CH_W = 8;

	// hue scale and sector bases
	localparam logic [15:0]     HUE_SCALE  = 16'd43;
	localparam logic [CH_W-1:0] BASE_RED   = 8'd0;
	localparam logic [CH_W-1:0] BASE_GREEN = 8'd85;
	localparam logic [CH_W-1:0] BASE_BLUE  = 8'd171;

	// channel that holds the maximum
	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// one quotient bit of a restoring division
	typedef struct packed {
		logic [CH_W-1:0] rem;
		logic            qbit;
	} div_bit_t;

	// payload of the divider stages, both divisions side by side
	typedef struct packed {
		logic [CH_W-1:0] sat_rem;
		logic [CH_W-1:0] sat_num;
		logic [CH_W-1:0] sat_q;
		logic [CH_W-1:0] sat_div;
		logic [CH_W-1:0] hue_rem;
		logic [CH_W-1:0] hue_num;
		logic [CH_W-1:0] hue_q;
		logic [CH_W-1:0] hue_div;
		sector_t         sector;
		logic            neg;
		logic            grey;
	} div_pipe_t;

	// shift one numerator bit into the remainder and subtract the divisor if it fits
	function automatic div_bit_t div_bit(input logic [CH_W-1:0] rem, input logic bit_in,
			input logic [CH_W-1:0] dvs);
		logic [CH_W:0] trial;
		div_bit_t      res;
		trial = {rem, bit_in};
		if (trial >= {1'b0, dvs}) begin
			trial    = trial - {1'b0, dvs};
			res.qbit = 1'b1;
		end else begin
			res.qbit = 1'b0;
		end
		res.rem = trial[CH_W-1:0];
		return res;
	endfunction

endpackage

### sv/rgb2hsv_front.sv
// rgb2hsv_front: max, min, spread and hue difference, then the two numerators
module rgb2hsv_front
	import rgb2hsv_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	output logic            out_valid,
	input  logic            out_ready,
	output div_pipe_t       out_data
);

	logic            valid_s1, valid_s2, ready_s1, ready_s2;
	logic [CH_W-1:0] hi, lo, op_a, op_b;
	sector_t         sector;
	logic [CH_W:0]   diff, absd;
	logic [CH_W-1:0] hi_s1, spread_s1, absd_s1;
	sector_t         sector_s1;
	logic            neg_s1;
	logic [15:0]     sat_num, hue_num;
	div_pipe_t       data_s2;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// pick the maximum channel, ties to the earlier one
	always_comb begin
		if (red >= green && red >= blue) begin
			sector = SEC_RED;
			hi     = red;
			op_a   = green;
			op_b   = blue;
		end else if (green >= blue) begin
			sector = SEC_GREEN;
			hi     = green;
			op_a   = blue;
			op_b   = red;
		end else begin
			sector = SEC_BLUE;
			hi     = blue;
			op_a   = red;
			op_b   = green;
		end
		lo = red;
		if (green < lo) lo = green;
		if (blue < lo) lo = blue;
		diff = {1'b0, op_a} - {1'b0, op_b};
		absd = diff[CH_W] ? ({(CH_W+1){1'b0}} - diff) : diff;
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			hi_s1     <= hi;
			spread_s1 <= hi - lo;
			absd_s1   <= absd[CH_W-1:0];
			sector_s1 <= sector;
			neg_s1    <= diff[CH_W];
		end
	end

	// numerators: 255 * spread and 43 * |difference|
	assign sat_num = {spread_s1, 8'd0} - {8'd0, spread_s1};
	assign hue_num = {8'd0, absd_s1} * HUE_SCALE;

	// stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			data_s2.sat_rem <= sat_num[15:8];
			data_s2.sat_num <= sat_num[7:0];
			data_s2.sat_q   <= '0;
			data_s2.sat_div <= hi_s1;
			data_s2.hue_rem <= hue_num[15:8];
			data_s2.hue_num <= hue_num[7:0];
			data_s2.hue_q   <= '0;
			data_s2.hue_div <= spread_s1;
			data_s2.sector  <= sector_s1;
			data_s2.neg     <= neg_s1;
			data_s2.grey    <= (spread_s1 == '0);
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

### sv/rgb2hsv_div_stage.sv
// rgb2hsv_div_stage: two restoring division steps for saturation and hue, registered
module rgb2hsv_div_stage
	import rgb2hsv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_pipe_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output div_pipe_t out_data
);

	logic      valid_s1;
	div_pipe_t data_s1, nxt;
	div_bit_t  sat_a, sat_b, hue_a, hue_b;

	assign in_ready = !valid_s1 || out_ready;

	// two quotient bits per lane
	always_comb begin
		sat_a = div_bit(in_data.sat_rem, in_data.sat_num[CH_W-1], in_data.sat_div);
		sat_b = div_bit(sat_a.rem, in_data.sat_num[CH_W-2], in_data.sat_div);
		hue_a = div_bit(in_data.hue_rem, in_data.hue_num[CH_W-1], in_data.hue_div);
		hue_b = div_bit(hue_a.rem, in_data.hue_num[CH_W-2], in_data.hue_div);
		nxt         = in_data;
		nxt.sat_rem = sat_b.rem;
		nxt.sat_num = {in_data.sat_num[CH_W-3:0], 2'b00};
		nxt.sat_q   = {in_data.sat_q[CH_W-3:0], sat_a.qbit, sat_b.qbit};
		nxt.hue_rem = hue_b.rem;
		nxt.hue_num = {in_data.hue_num[CH_W-3:0], 2'b00};
		nxt.hue_q   = {in_data.hue_q[CH_W-3:0], hue_a.qbit, hue_b.qbit};
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

### sv/rgb2hsv_out.sv
// rgb2hsv_out: hue assembly, grey override and the output register
module rgb2hsv_out
	import rgb2hsv_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  div_pipe_t       in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CH_W-1:0] hue,
	output logic [CH_W-1:0] saturation,
	output logic [CH_W-1:0] brightness
);

	logic            valid_q;
	logic [CH_W-1:0] base, offs, hue_n;
	logic [CH_W-1:0] hue_q, sat_q, bright_q;

	assign in_ready = !valid_q || out_ready;

	// sector base plus signed quotient, wrapping modulo 256
	always_comb begin
		case (in_data.sector)
			SEC_RED:   base = BASE_RED;
			SEC_GREEN: base = BASE_GREEN;
			SEC_BLUE:  base = BASE_BLUE;
			default:   base = BASE_RED;
		endcase
		offs  = in_data.neg ? ({CH_W{1'b0}} - in_data.hue_q) : in_data.hue_q;
		hue_n = base + offs;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// grey pixels give all zero
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hue_q    <= in_data.grey ? '0 : hue_n;
			sat_q    <= in_data.grey ? '0 : in_data.sat_q;
			bright_q <= in_data.grey ? '0 : in_data.sat_div;
		end
	end

	assign out_valid  = valid_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = bright_q;

endmodule

### sv/integer_rgb_to_hsv.sv
// integer_rgb_to_hsv: top level of the 8-bit rgb to hsv stream converter
// Takes one pixel per clock when the output side does not stall and returns one hsv
// result per pixel. Two register stages find
// the max, min and spread and form the numerators 255*spread and 43*|difference|;
// four divider stages then resolve two quotient bits each for both divisions in
// parallel; a last register adds the sector base and applies the grey rule (a grey
// pixel gives hue, saturation and brightness all zero). Every stage holds its item
// under backpressure, so a stalled output loses or repeats nothing.
module integer_rgb_to_hsv
	import rgb2hsv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // hue [7:0], saturation [15:8], brightness [23:16]
);

	localparam int unsigned DIV_STAGES = CH_W / 2;

	logic      vld   [DIV_STAGES+1];
	logic      rdy   [DIV_STAGES+1];
	div_pipe_t dat   [DIV_STAGES+1];
	logic [CH_W-1:0] hue, saturation, brightness;

	// front stages
	rgb2hsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.red       (s_axis_tdata[7:0]),
		.green     (s_axis_tdata[15:8]),
		.blue      (s_axis_tdata[23:16]),
		.out_valid (vld[0]),
		.out_ready (rdy[0]),
		.out_data  (dat[0])
	);

	// divider chain
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		rgb2hsv_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.in_data   (dat[i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.out_data  (dat[i+1])
		);
	end

	// result stage
	rgb2hsv_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (vld[DIV_STAGES]),
		.in_ready   (rdy[DIV_STAGES]),
		.in_data    (dat[DIV_STAGES]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	assign m_axis_tdata = {brightness, saturation, hue};

endmodule
